// ===== src/rpy_pkg.sv =====
// rpy_pkg: shared widths, fixed-point constants, pipeline depths and types
// for the pair mobility block; used by every file under src except rpy_delay
// depends on nothing
package rpy_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	// register and shift-count widths
	localparam int HW   = 16;
	localparam int SHW  = 5;
	localparam int FRAC = 30;

	// square root unit: 64-bit radicand, 4 result bits per stage
	localparam int SQRT_RAD_W = 64;
	localparam int SQRT_STEPS = 4;
	localparam int SQRT_NST   = SQRT_RAD_W / 2 / SQRT_STEPS;

	// divider: 79-bit dividend, 31-bit divisor, 33 quotient bits, 3 per stage
	localparam int DIV_NW    = 79;
	localparam int DIV_DW    = 31;
	localparam int DIV_QB    = 33;
	localparam int DIV_STEPS = 3;
	localparam int DIV_NST   = DIV_QB / DIV_STEPS;

	// front end 7, root, divider setup 1, divider, back end 6
	localparam int LATENCY = 7 + SQRT_NST + 1 + DIV_NST + 1 + 6;

	localparam logic [30:0] ONE_Q30       = 31'd1073741824;
	localparam logic [30:0] CRPI_Q30      = 31'd1427368373;
	localparam logic [31:0] TWOPI_BY3_Q30 = 32'd2248839617;
	localparam logic [32:0] TWOPI_Q30     = 33'd6746518852;
	localparam logic [27:0] C3_Q30        = 28'd170379549;
	localparam logic [25:0] C7_Q30        = 26'd56793183;
	localparam logic [27:0] FOURPI_Q24    = 28'd210828714;

	// the six unique tensor entries: xx xy xz yy yz zz
	localparam int NENT = 6;
	localparam int PAIR_I [NENT] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_J [NENT] = '{0, 1, 2, 1, 2, 2};
	localparam logic [NENT-1:0] DIAG_MASK = 6'b101001;

	typedef struct packed {
		logic [2:0][FRAC-1:0] mag;
		logic [2:0]           neg;
		logic [SHW-1:0]       s;
		logic [SHW-1:0]       t;
		logic                 far;
		logic                 hz;
	} side_t;

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== src/rpy_delay.sv =====
// rpy_delay: fixed-length shift line that carries side data and valid bits
// alongside the root and divider pipelines
// depends on nothing
module rpy_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] d_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) d_q[i] <= '0;
		end else begin
			d_q[0] <= din;
			for (int i = 1; i < D; i++) d_q[i] <= d_q[i-1];
		end
	end

	assign dout = d_q[D-1];

endmodule

// ===== src/rpy_isqrt.sv =====
// rpy_isqrt: pipelined digit-by-digit integer square root, floor result
// depends on rpy_pkg for radicand width and steps per stage
module rpy_isqrt (
	input  logic                              clk,
	input  logic [rpy_pkg::SQRT_RAD_W-1:0]    rad,
	output logic [rpy_pkg::SQRT_RAD_W/2-1:0]  root
);
	import rpy_pkg::*;

	localparam int RB = SQRT_RAD_W / 2;

	typedef struct packed {
		logic [SQRT_RAD_W-1:0] rad;
		logic [RB+1:0]         rem;
		logic [RB-1:0]         root;
	} sq_state_t;

	function automatic sq_state_t sq_iter(input sq_state_t st);
		logic [RB+1:0] ext;
		logic [RB+1:0] trial;
		sq_state_t     nx;
		ext    = {st.rem[RB-1:0], st.rad[SQRT_RAD_W-1 -: 2]};
		trial  = {st.root, 2'b01};
		nx.rad = {st.rad[SQRT_RAD_W-3:0], 2'b00};
		if (ext >= trial) begin
			nx.rem  = ext - trial;
			nx.root = {st.root[RB-2:0], 1'b1};
		end else begin
			nx.rem  = ext;
			nx.root = {st.root[RB-2:0], 1'b0};
		end
		return nx;
	endfunction

	sq_state_t st_s [SQRT_NST];

	for (genvar k = 0; k < SQRT_NST; k++) begin : g_stage
		sq_state_t cur;
		sq_state_t nxt;
		if (k == 0) begin : g_first
			always_comb begin
				cur.rad  = rad;
				cur.rem  = '0;
				cur.root = '0;
			end
		end else begin : g_next
			assign cur = st_s[k-1];
		end
		always_comb begin
			nxt = cur;
			for (int i = 0; i < SQRT_STEPS; i++) nxt = sq_iter(nxt);
		end
		always_ff @(posedge clk) begin
			st_s[k] <= nxt;
		end
	end

	assign root = st_s[SQRT_NST-1].root;

endmodule

// ===== src/rpy_div.sv =====
// rpy_div: pipelined restoring divider, fixed quotient width with an
// overflow flag for quotients that do not fit
// depends on rpy_pkg for widths and steps per stage
module rpy_div (
	input  logic                        clk,
	input  logic [rpy_pkg::DIV_NW-1:0]  num,
	input  logic [rpy_pkg::DIV_DW-1:0]  den,
	output logic [rpy_pkg::DIV_QB-1:0]  quo,
	output logic                        ovf
);
	import rpy_pkg::*;

	localparam int HIW = DIV_NW - DIV_QB;

	typedef struct packed {
		logic [DIV_QB-1:0] low;
		logic [DIV_DW-1:0] rem;
		logic [DIV_DW-1:0] den;
		logic              ovf;
	} div_state_t;

	function automatic div_state_t div_iter(input div_state_t st);
		logic [DIV_DW:0] ext;
		logic [DIV_DW:0] dif;
		logic            ge;
		div_state_t      nx;
		ext    = {st.rem, st.low[DIV_QB-1]};
		dif    = ext - {1'b0, st.den};
		ge     = ext >= {1'b0, st.den};
		nx     = st;
		nx.low = {st.low[DIV_QB-2:0], ge};
		nx.rem = ge ? dif[DIV_DW-1:0] : ext[DIV_DW-1:0];
		return nx;
	endfunction

	div_state_t st_s [DIV_NST+1];
	div_state_t init;
	logic [HIW-1:0] hi;

	// quotient overflows when the top part already reaches the divisor
	always_comb begin
		hi        = num[DIV_NW-1:DIV_QB];
		init.ovf  = hi >= HIW'(den);
		init.rem  = hi[DIV_DW-1:0];
		init.low  = num[DIV_QB-1:0];
		init.den  = den;
	end

	always_ff @(posedge clk) begin
		st_s[0] <= init;
	end

	for (genvar k = 1; k <= DIV_NST; k++) begin : g_stage
		div_state_t nxt;
		always_comb begin
			nxt = st_s[k-1];
			for (int i = 0; i < DIV_STEPS; i++) nxt = div_iter(nxt);
		end
		always_ff @(posedge clk) begin
			st_s[k] <= nxt;
		end
	end

	assign quo = st_s[DIV_NST].low;
	assign ovf = st_s[DIV_NST].ovf;

endmodule

// ===== src/rpy_pair_mobility_block.sv =====
// rpy_pair_mobility_block: top level of the pair mobility pipeline
// depends on rpy_pkg, rpy_delay, rpy_isqrt, rpy_div
//
// usage
// - hydro_strength is written through cfg_we / cfg_wdata with no wait;
//   write it only while no pair is in flight
// - a pair transfer happens on a rising edge with start high and busy low;
//   busy is always low, so a new pair can enter on every cycle
// - each result is on entry_* / overlap_branch for exactly one cycle, marked
//   by done; the receiver cannot hold results off and none is buffered
// - throughput: one pair per cycle, fully pipelined
// - pipeline: the result transfer follows the start transfer through
//   7 front-end stages, 8 root stages, 1 divider setup stage, 12 divider stages
//   and 6 back-end stages; the root unit and the divider pipelines set the depth
// - results come out in the order the pairs went in
// - reset clears hydro_strength and all valid bits; pairs in flight are lost
// - with hydro_strength zero every entry and overlap_branch read as zero
module rpy_pair_mobility_block #(
	parameter int COORD_WIDTH = rpy_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [rpy_pkg::HW-1:0]        cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	output logic                          done,
	output logic signed [31:0]            entry_xx,
	output logic signed [31:0]            entry_xy,
	output logic signed [31:0]            entry_xz,
	output logic signed [31:0]            entry_yy,
	output logic signed [31:0]            entry_yz,
	output logic signed [31:0]            entry_zz,
	output logic                          overlap_branch
);
	import rpy_pkg::*;

	localparam int W = COORD_WIDTH;

	logic [HW-1:0] hs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
		end else if (cfg_we) begin
			hs_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// ---------------- front end ----------------
	logic signed [W-1:0] fa [3];
	logic signed [W-1:0] sb [3];
	logic signed [W:0]   dif [3];

	always_comb begin
		fa[0] = first_x;  fa[1] = first_y;  fa[2] = first_z;
		sb[0] = second_x; sb[1] = second_y; sb[2] = second_z;
		for (int i = 0; i < 3; i++) dif[i] = (W+1)'(sb[i]) - (W+1)'(fa[i]);
	end

	logic [6:0]       v_s;   // valid bits, stages 1..7
	logic [W:0]       ae_s1 [3];
	logic [2:0]       neg_s1;
	logic             hz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[5:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ae_s1[i]  <= dif[i][W] ? (W+1)'(-dif[i]) : (W+1)'(dif[i]);
			neg_s1[i] <= dif[i][W];
		end
		hz_s1 <= hs_q == '0;
	end

	// stage 2: largest magnitude and the pre-shift that brings it below 2^30
	logic [W:0]      mx;
	logic [SHW-1:0]  sv;
	logic [W:0]      ae_s2 [3];
	logic [2:0]      neg_s2;
	logic            hz_s2;
	logic [SHW-1:0]  s_s2;

	always_comb begin
		mx = (ae_s1[0] > ae_s1[1]) ? ae_s1[0] : ae_s1[1];
		mx = (mx > ae_s1[2]) ? mx : ae_s1[2];
		sv = '0;
		for (int i = FRAC; i <= W; i++) begin
			if (mx[i]) sv = SHW'(i - FRAC + 1);
		end
	end

	always_ff @(posedge clk) begin
		ae_s2  <= ae_s1;
		neg_s2 <= neg_s1;
		hz_s2  <= hz_s1;
		s_s2   <= sv;
	end

	// stage 3: shift down
	side_t sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sd_s3.mag[i] <= FRAC'(ae_s2[i] >> s_s2);
		sd_s3.neg <= neg_s2;
		sd_s3.s   <= s_s2;
		sd_s3.t   <= '0;
		sd_s3.far <= 1'b0;
		sd_s3.hz  <= hz_s2;
	end

	// stage 4: squares
	logic [2*FRAC-1:0] sqr_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sqr_s4[i] <= (2*FRAC)'(sd_s3.mag[i]) * (2*FRAC)'(sd_s3.mag[i]);
		sd_s4 <= sd_s3;
	end

	// stage 5: squared length, zero clamped to one lsb
	logic [61:0] sqsum;
	logic [61:0] sq_s5;
	logic [31:0] hh_s5;

	assign sqsum = 62'(sqr_s4[0]) + 62'(sqr_s4[1]) + 62'(sqr_s4[2]);

	always_ff @(posedge clk) begin
		sq_s5 <= (sqsum == '0) ? 62'd1 : sqsum;
		hh_s5 <= 32'(hs_q) * 32'(hs_q);
		sd_s5 <= sd_s4;
	end

	// stage 6: normalize count and the branch threshold
	logic [SHW-1:0] tv;
	side_t          sd6_nx;
	logic [61:0]    sq_s6;
	logic           big_s6;
	logic [59:0]    sqsh_s6;
	logic [59:0]    thr_s6;

	always_comb begin
		tv = '0;
		for (int j = 0; j <= 30; j++) begin
			if (|sq_s5[2*j +: 2]) tv = SHW'(30 - j);
		end
		sd6_nx   = sd_s5;
		sd6_nx.t = tv;
	end

	always_ff @(posedge clk) begin
		sq_s6   <= sq_s5;
		big_s6  <= (sd_s5.s != '0) || (sq_s5 >= 62'h10_0000_0000) || sd_s5.hz;
		sqsh_s6 <= 60'(sq_s5[35:0]) << 24;
		thr_s6  <= 60'(FOURPI_Q24) * 60'(hh_s5);
		sd_s6   <= sd6_nx;
	end

	// stage 7: normalized radicand and branch decision
	logic [61:0] sqn_s7;
	side_t       sd7_nx;

	always_comb begin
		sd7_nx     = sd_s6;
		sd7_nx.far = big_s6 || (sqsh_s6 >= thr_s6);
	end

	always_ff @(posedge clk) begin
		sqn_s7 <= sq_s6 << {sd_s6.t, 1'b0};
		sd_s7  <= sd7_nx;
	end

	// ---------------- square root ----------------
	logic [SQRT_RAD_W/2-1:0] root_w;
	side_t                   sd_r;
	logic                    v_r;

	rpy_isqrt u_isqrt (
		.clk  (clk),
		.rad  ({2'b00, sqn_s7}),
		.root (root_w)
	);

	rpy_delay #(.W($bits(side_t)), .D(SQRT_NST)) u_dly_sq (
		.clk (clk), .arst_n (arst_n), .din (sd_s7), .dout (sd_r)
	);

	rpy_delay #(.W(1), .D(SQRT_NST)) u_dly_sq_v (
		.clk (clk), .arst_n (arst_n), .din (v_s[6]), .dout (v_r)
	);

	// ---------------- divider setup ----------------
	logic [DIV_DW-1:0] rt;
	logic [6:0]        amt;
	logic [DIV_DW-1:0] xu [3];

	assign rt  = root_w[DIV_DW-1:0];
	assign amt = 7'd32 - 7'(sd_r.s) + 7'(sd_r.t);

	always_comb begin
		for (int i = 0; i < 3; i++) xu[i] = DIV_DW'(61'(sd_r.mag[i]) << sd_r.t);
	end

	logic [DIV_NW-1:0] nm_s8;
	logic [DIV_DW-1:0] dn_s8;
	logic [DIV_NW-1:0] nu_s8 [3];
	logic [DIV_DW-1:0] rt_s8;
	side_t             sd_s8;
	logic              v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_r;
		end
	end

	// far: h * 2^a / rt ; overlap: rt * 2^(30-t) / h ; unit vector: x * 2^32 / rt
	always_ff @(posedge clk) begin
		if (sd_r.far) begin
			nm_s8 <= DIV_NW'(hs_q) << amt;
			dn_s8 <= rt;
		end else begin
			nm_s8 <= DIV_NW'(rt) << (SHW'(30) - sd_r.t);
			dn_s8 <= DIV_DW'(hs_q);
		end
		for (int i = 0; i < 3; i++) nu_s8[i] <= DIV_NW'(xu[i]) << 32;
		rt_s8 <= rt;
		sd_s8 <= sd_r;
	end

	// ---------------- dividers ----------------
	logic [DIV_QB-1:0] qm;
	logic              om_ovf;
	logic [DIV_QB-1:0] qu [3];
	logic              qu_ovf [3];
	side_t             sd_d;
	logic              v_d;

	rpy_div u_div_main (
		.clk (clk), .num (nm_s8), .den (dn_s8), .quo (qm), .ovf (om_ovf)
	);

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		rpy_div u_div_u (
			.clk (clk), .num (nu_s8[i]), .den (rt_s8), .quo (qu[i]), .ovf (qu_ovf[i])
		);
	end

	rpy_delay #(.W($bits(side_t)), .D(DIV_NST + 1)) u_dly_div (
		.clk (clk), .arst_n (arst_n), .din (sd_s8), .dout (sd_d)
	);

	rpy_delay #(.W(1), .D(DIV_NST + 1)) u_dly_div_v (
		.clk (clk), .arst_n (arst_n), .din (v_s8), .dout (v_d)
	);

	// ---------------- back end ----------------
	logic [5:0] vb_s;   // valid bits, stages 9..14

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_s <= '0;
		end else begin
			vb_s <= {vb_s[4:0], v_d};
		end
	end

	// stage 9: saturate the ratio, unit vector components
	logic [31:0] qp_s9;
	logic [30:0] u_s9 [3];
	side_t       sd_s9;

	always_ff @(posedge clk) begin
		if (sd_d.far) begin
			qp_s9 <= (om_ovf || qm > 33'h0_8000_0000) ? 32'h8000_0000 : qm[31:0];
		end else begin
			qp_s9 <= (om_ovf || qm[32]) ? 32'hFFFF_FFFF : qm[31:0];
		end
		for (int i = 0; i < 3; i++) u_s9[i] <= qu_ovf[i] ? 31'h4000_0000 : qu[i][32:2];
		sd_s9 <= sd_d;
	end

	// stage 10: first products
	logic [30:0] q2_s10;
	logic [29:0] cq_s10;
	logic [30:0] oom_s10;
	logic [27:0] ok_s10;
	logic [30:0] ddm_s10 [NENT];
	logic [NENT-1:0] dds_s10;
	side_t       sd_s10;

	always_ff @(posedge clk) begin
		q2_s10  <= 31'((64'(qp_s9) * 64'(qp_s9)) >> 32);
		cq_s10  <= 30'((64'(CRPI_Q30) * 64'(qp_s9)) >> 32);
		oom_s10 <= ONE_Q30 - 31'((60'(C3_Q30) * 60'(qp_s9)) >> 30);
		ok_s10  <= 28'((58'(C7_Q30) * 58'(qp_s9)) >> 30);
		for (int p = 0; p < NENT; p++) begin
			ddm_s10[p] <= 31'((62'(u_s9[PAIR_I[p]]) * 62'(u_s9[PAIR_J[p]])) >> 30);
			dds_s10[p] <= sd_s9.neg[PAIR_I[p]] ^ sd_s9.neg[PAIR_J[p]];
		end
		sd_s10 <= sd_s9;
	end

	// stage 11: far-field correction terms
	logic [30:0] t1_s11;
	logic [30:0] t2_s11;
	logic [29:0] cq_s11;
	logic [30:0] oom_s11;
	logic [27:0] ok_s11;
	logic [30:0] ddm_s11 [NENT];
	logic [NENT-1:0] dds_s11;
	side_t       sd_s11;

	always_ff @(posedge clk) begin
		t1_s11  <= 31'((64'(TWOPI_BY3_Q30) * 64'(q2_s10)) >> 32);
		t2_s11  <= 31'((64'(TWOPI_Q30) * 64'(q2_s10)) >> 32);
		cq_s11  <= cq_s10;
		oom_s11 <= oom_s10;
		ok_s11  <= ok_s10;
		ddm_s11 <= ddm_s10;
		dds_s11 <= dds_s10;
		sd_s11  <= sd_s10;
	end

	// stage 12: diagonal weight and signed coupling weight
	logic [31:0] onept1;
	logic        kneg;
	logic [30:0] kin;
	logic [31:0] om1f;
	logic [30:0] kf;

	always_comb begin
		onept1 = 32'(ONE_Q30) + 32'(t1_s11);
		kneg   = t2_s11 > ONE_Q30;
		kin    = kneg ? (t2_s11 - ONE_Q30) : (ONE_Q30 - t2_s11);
		om1f   = 32'((62'(cq_s11) * 62'(onept1)) >> 30);
		kf     = 31'((61'(cq_s11) * 61'(kin)) >> 30);
	end

	logic [31:0] om1_s12;
	logic [30:0] km_s12;
	logic        kn_s12;
	logic [30:0] ddm_s12 [NENT];
	logic [NENT-1:0] dds_s12;
	side_t       sd_s12;

	always_ff @(posedge clk) begin
		om1_s12 <= sd_s11.far ? om1f : 32'(oom_s11);
		km_s12  <= sd_s11.far ? kf : 31'(ok_s11);
		kn_s12  <= sd_s11.far & kneg;
		ddm_s12 <= ddm_s11;
		dds_s12 <= dds_s11;
		sd_s12  <= sd_s11;
	end

	// stage 13: coupling products, truncated toward zero
	logic signed [33:0] pr_s13 [NENT];
	logic [31:0]        om1_s13;
	side_t              sd_s13;
	logic [31:0]        pm [NENT];

	always_comb begin
		for (int p = 0; p < NENT; p++) pm[p] = 32'((62'(km_s12) * 62'(ddm_s12[p])) >> 30);
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NENT; p++)
			pr_s13[p] <= (kn_s12 ^ dds_s12[p]) ? -34'(pm[p]) : 34'(pm[p]);
		om1_s13 <= om1_s12;
		sd_s13  <= sd_s12;
	end

	// stage 14: add diagonal weight, saturate, output register
	logic [31:0] ent_s14 [NENT];
	logic        ovl_s14;

	always_ff @(posedge clk) begin
		for (int p = 0; p < NENT; p++) begin
			if (sd_s13.hz) begin
				ent_s14[p] <= '0;
			end else if (DIAG_MASK[p]) begin
				ent_s14[p] <= sat32($signed({3'b000, om1_s13}) + 35'(pr_s13[p]));
			end else begin
				ent_s14[p] <= sat32(35'(pr_s13[p]));
			end
		end
		ovl_s14 <= ~sd_s13.far & ~sd_s13.hz;
	end

	assign done           = vb_s[5];
	assign entry_xx       = ent_s14[0];
	assign entry_xy       = ent_s14[1];
	assign entry_xz       = ent_s14[2];
	assign entry_yy       = ent_s14[3];
	assign entry_yz       = ent_s14[4];
	assign entry_zz       = ent_s14[5];
	assign overlap_branch = ovl_s14;

endmodule

// ===== src/rpy_checker.sv =====
// rpy_checker: port-level assertions for the pair mobility block, bound to
// the top level; depends on rpy_pkg for latency and register width
module rpy_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   cfg_we,
	input logic [rpy_pkg::HW-1:0] cfg_wdata,
	input logic                   done,
	input logic signed [31:0]     entry_xx,
	input logic signed [31:0]     entry_xy,
	input logic signed [31:0]     entry_xz,
	input logic signed [31:0]     entry_yy,
	input logic signed [31:0]     entry_yz,
	input logic signed [31:0]     entry_zz,
	input logic                   overlap_branch
);
	import rpy_pkg::*;

	logic [HW-1:0] hs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
		end else if (cfg_we) begin
			hs_q <= cfg_wdata;
		end
	end

	// the block never refuses a transfer
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");

	// every result comes from a transfer exactly one latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without matching transfer");

	// interaction switched off gives an all-zero tensor
	a_zero_h: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hs_q == '0) |-> (entry_xx == 0 && entry_xy == 0 && entry_xz == 0 &&
			entry_yy == 0 && entry_yz == 0 && entry_zz == 0 && !overlap_branch))
		else $error("nonzero tensor with zero interaction strength");

	// overlap weights keep the diagonal non-negative
	a_ovl_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overlap_branch) |-> (!entry_xx[31] && !entry_yy[31] && !entry_zz[31]))
		else $error("negative diagonal in overlap branch");

endmodule

bind rpy_pair_mobility_block rpy_checker u_rpy_checker (.*);
